### hw/rtl/rational_arithmetic_unit_top_defines.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RAU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rau: check failed");

// next-cycle implication, disabled during reset
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rau: check failed");

`endif

### hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Types, codes and sizes shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int PORT_BITS     = 32;
	localparam int DEN_BITS      = 31;
	localparam int QUEUE_DEPTH   = 2;

	// command codes
	localparam logic [2:0] CMD_NORM = 3'd0;
	localparam logic [2:0] CMD_ADD  = 3'd1;
	localparam logic [2:0] CMD_SUB  = 3'd2;
	localparam logic [2:0] CMD_MUL  = 3'd3;
	localparam logic [2:0] CMD_DIV  = 3'd4;
	localparam logic [2:0] CMD_CMP  = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DIVZERO  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_INVALID  = 2'd3;

	// compare outcomes
	localparam logic [1:0] ORD_LESS = 2'd0;
	localparam logic [1:0] ORD_EQ   = 2'd1;
	localparam logic [1:0] ORD_GT   = 2'd2;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         order;
		logic [1:0]         status;
	} rsp_t;

	// control part of one queued job
	typedef struct packed {
		logic       reduce;
		logic       neg;
		logic [1:0] order;
		logic [1:0] status;
	} job_ctl_t;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_MUL0,
		FR_MUL1,
		FR_MUL2,
		FR_FIN
	} front_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_GCD,
		BK_SHIFT,
		BK_DIVN,
		BK_DIVD,
		BK_CHECK
	} back_state_t;

endpackage

`default_nettype wire

### hw/rtl/rau_front.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Accepts commands, forms cross products with one shared multiplier and
// classifies each transaction into a reduction job or a finished answer.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_front #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire rau_pkg::req_t           req,
	output logic                         push,
	output rau_pkg::job_ctl_t            job_ctl,
	output logic [2*WORD_BITS:0]         job_nmag,
	output logic [2*WORD_BITS:0]         job_dmag,
	input  wire logic                    full
);
	import rau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int MW = 2 * WORD_BITS + 1;

	front_state_t state_q, state_d;

	logic [2:0]            cmd_q;
	logic signed [W-1:0]   an_q, ad_q, bn_q, bd_q;
	logic signed [2*W-1:0] p0_q, p1_q, p2_q;

	logic signed [W-1:0]   mul_a, mul_b;
	logic signed [2*W-1:0] prod;

	logic signed [MW-1:0]  s0, s1, s2, sum;
	logic [MW-1:0]         m0, m1, msum, ma, md;
	logic                  bad_den;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE: if (start) state_d = FR_MUL0;
			FR_MUL0: state_d = FR_MUL1;
			FR_MUL1: state_d = FR_MUL2;
			FR_MUL2: state_d = FR_FIN;
			FR_FIN:  if (!full) state_d = FR_IDLE;
			default: state_d = FR_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		busy = (state_q != FR_IDLE);
		push = (state_q == FR_FIN) && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FR_IDLE;
		else state_q <= state_d;
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = an_q;
		mul_b = (cmd_q == CMD_MUL) ? bn_q : bd_q;
		unique case (state_q)
			FR_MUL1: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
			FR_MUL2: begin
				mul_a = ad_q;
				mul_b = bd_q;
			end
			default: ;
		endcase
		prod = mul_a * mul_b;
	end

	// operand capture and product registers
	always_ff @(posedge clk) begin
		if (state_q == FR_IDLE && start) begin
			cmd_q <= req.cmd;
			an_q  <= req.a_num[W-1:0];
			ad_q  <= req.a_den[W-1:0];
			bn_q  <= req.b_num[W-1:0];
			bd_q  <= req.b_den[W-1:0];
		end
		if (state_q == FR_MUL0) p0_q <= prod;
		if (state_q == FR_MUL1) p1_q <= prod;
		if (state_q == FR_MUL2) p2_q <= prod;
	end

	// cross-product combination and magnitudes
	always_comb begin
		s0   = MW'(p0_q);
		s1   = MW'(p1_q);
		s2   = MW'(p2_q);
		sum  = (cmd_q == CMD_SUB) ? (s0 - s1) : (s0 + s1);
		m0   = s0[MW-1] ? MW'(-s0) : MW'(s0);
		m1   = s1[MW-1] ? MW'(-s1) : MW'(s1);
		msum = sum[MW-1] ? MW'(-sum) : MW'(sum);
		ma   = an_q[W-1] ? MW'(-MW'(an_q)) : MW'(an_q);
		md   = ad_q[W-1] ? MW'(-MW'(ad_q)) : MW'(ad_q);
		bad_den = ad_q[W-1] || (ad_q == '0) || bd_q[W-1] || (bd_q == '0);
	end

	// job classification
	always_comb begin
		job_ctl.reduce = 1'b0;
		job_ctl.neg    = 1'b0;
		job_ctl.order  = ORD_LESS;
		job_ctl.status = ST_OK;
		job_nmag       = '0;
		job_dmag       = '0;
		priority if (cmd_q == CMD_NORM) begin
			job_ctl.reduce = 1'b1;
			job_ctl.neg    = an_q[W-1] ^ ad_q[W-1];
			job_nmag       = ma;
			job_dmag       = md;
		end else if (cmd_q > CMD_CMP || bad_den) begin
			job_ctl.status = ST_INVALID;
		end else if (cmd_q == CMD_ADD || cmd_q == CMD_SUB) begin
			job_ctl.reduce = 1'b1;
			job_ctl.neg    = sum[MW-1];
			job_nmag       = msum;
			job_dmag       = MW'(s2);
		end else if (cmd_q == CMD_MUL) begin
			job_ctl.reduce = 1'b1;
			job_ctl.neg    = s0[MW-1];
			job_nmag       = m0;
			job_dmag       = MW'(s2);
		end else if (cmd_q == CMD_DIV) begin
			job_ctl.reduce = 1'b1;
			job_ctl.neg    = s0[MW-1] ^ s1[MW-1];
			job_nmag       = m0;
			job_dmag       = m1;
		end else begin
			job_ctl.order = (p0_q < p1_q) ? ORD_LESS : ((p0_q == p1_q) ? ORD_EQ : ORD_GT);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/rau_queue.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit job queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_queue #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire rau_pkg::job_ctl_t    in_ctl,
	input  wire logic [2*WORD_BITS:0] in_nmag,
	input  wire logic [2*WORD_BITS:0] in_dmag,
	output logic                      full,
	output logic                      empty,
	input  wire logic                 pop,
	output rau_pkg::job_ctl_t         out_ctl,
	output logic [2*WORD_BITS:0]      out_nmag,
	output logic [2*WORD_BITS:0]      out_dmag
);
	import rau_pkg::*;

	localparam int MW = 2 * WORD_BITS + 1;
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_ctl_t        ctl_mem  [QUEUE_DEPTH];
	logic [MW-1:0]   nmag_mem [QUEUE_DEPTH];
	logic [MW-1:0]   dmag_mem [QUEUE_DEPTH];

	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	// status flags
	always_comb begin
		full  = (count_q == CW'(QUEUE_DEPTH));
		empty = (count_q == '0);
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ctl_mem[wr_ptr_q]  <= in_ctl;
			nmag_mem[wr_ptr_q] <= in_nmag;
			dmag_mem[wr_ptr_q] <= in_dmag;
		end
	end

	// head of queue
	always_comb begin
		out_ctl  = ctl_mem[rd_ptr_q];
		out_nmag = nmag_mem[rd_ptr_q];
		out_dmag = dmag_mem[rd_ptr_q];
	end

endmodule

`default_nettype wire

### hw/rtl/rau_back.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit back end
// Reduces each reduction job by a binary greatest common divisor, divides
// both magnitudes by it bit-serially, checks range and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_back #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 empty,
	output logic                      pop,
	input  wire rau_pkg::job_ctl_t    job_ctl,
	input  wire logic [2*WORD_BITS:0] job_nmag,
	input  wire logic [2*WORD_BITS:0] job_dmag,
	output logic                      done,
	output rau_pkg::rsp_t             rsp
);
	import rau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int MW = 2 * WORD_BITS + 1;
	localparam int KW = $clog2(MW + 1);
	localparam logic [MW-1:0] LIMIT = MW'(1) << (W - 1);

	back_state_t state_q, state_d;

	logic          neg_q;
	logic [MW-1:0] u_q, v_q, n_q, d_q;
	logic [KW-1:0] k_q, cnt_q;
	logic [MW-1:0] dq_q, rem_q;

	logic [MW:0]         trial;
	logic                qbit;
	logic [MW-1:0]       rem_nx, quo_nx;
	logic                last_bit;
	logic                negf, ovf;
	logic [MW-1:0]       sval;
	logic signed [W-1:0] num_w;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty && job_ctl.reduce && job_dmag != '0) state_d = BK_GCD;
			end
			BK_GCD:   if (u_q == '0) state_d = BK_SHIFT;
			BK_SHIFT: if (k_q == '0) state_d = BK_DIVN;
			BK_DIVN:  if (last_bit) state_d = BK_DIVD;
			BK_DIVD:  if (last_bit) state_d = BK_CHECK;
			BK_CHECK: state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// queue handshake
	always_comb begin
		pop = (state_q == BK_IDLE) && !empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// restoring divider step, divisor is the gcd held in v_q
	always_comb begin
		trial    = {rem_q, dq_q[MW-1]};
		qbit     = (trial >= {1'b0, v_q});
		rem_nx   = qbit ? MW'(trial - {1'b0, v_q}) : trial[MW-1:0];
		quo_nx   = {dq_q[MW-2:0], qbit};
		last_bit = (cnt_q == KW'(MW - 1));
	end

	// range check and signed numerator
	always_comb begin
		negf  = neg_q && (n_q != '0);
		ovf   = (d_q > LIMIT - 1'b1) || (n_q > (negf ? LIMIT : LIMIT - 1'b1));
		sval  = negf ? MW'(-n_q) : n_q;
		num_w = sval[W-1:0];
	end

	// reduction datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				neg_q <= job_ctl.neg;
				u_q   <= job_nmag;
				v_q   <= job_dmag;
				n_q   <= job_nmag;
				d_q   <= job_dmag;
				k_q   <= '0;
			end
			BK_GCD: begin
				priority if (u_q == '0) begin
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q >= v_q) begin
					u_q <= u_q - v_q;
				end else begin
					v_q <= v_q - u_q;
				end
				dq_q  <= n_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			BK_SHIFT: begin
				if (k_q != '0) begin
					v_q <= v_q << 1;
					k_q <= k_q - 1'b1;
				end
				dq_q  <= n_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			BK_DIVN: begin
				if (last_bit) begin
					n_q   <= quo_nx;
					dq_q  <= d_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					dq_q  <= quo_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			BK_DIVD: begin
				if (last_bit) begin
					d_q <= quo_nx;
				end else begin
					dq_q  <= quo_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			BK_CHECK: ;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (pop && !(job_ctl.reduce && job_dmag != '0)) || (state_q == BK_CHECK);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !job_ctl.reduce) begin
			rsp.res_num <= '0;
			rsp.res_den <= '0;
			rsp.order   <= job_ctl.order;
			rsp.status  <= job_ctl.status;
		end else if (pop && job_dmag == '0) begin
			rsp.res_num <= '0;
			rsp.res_den <= '0;
			rsp.order   <= ORD_LESS;
			rsp.status  <= ST_DIVZERO;
		end else if (state_q == BK_CHECK) begin
			rsp.order <= ORD_LESS;
			if (ovf) begin
				rsp.res_num <= '0;
				rsp.res_den <= '0;
				rsp.status  <= ST_OVERFLOW;
			end else begin
				rsp.res_num <= PORT_BITS'(num_w);
				rsp.res_den <= DEN_BITS'(d_q);
				rsp.status  <= ST_OK;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/rational_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact fraction add, subtract, multiply, divide, compare and normalize with
// greatest common divisor reduction.
// ----------------------------------------------------------------------------
// Usage:
//   A command with two fractions is taken on req when start is high and busy
//   is low. Each transaction yields one result on rsp, shown for exactly one
//   cycle with done high; the receiver has no way to stall it.
//   The front end forms three products on one signed multiplier, then
//   classifies the transaction, and hands the job to a 2-entry queue, so it
//   can take the next command while the back end still works. The back end
//   answers jobs without reduction (compare, invalid operands, zero
//   denominator) straight from the queue. Reduction runs a binary gcd loop
//   at one step per cycle, shifts the gcd back by the common factors of two,
//   divides numerator and denominator bit-serially and then checks range.
//   Results leave in command order.
//   Reset clears the front end, the queue and the back end; no result is
//   pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit_top #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire rau_pkg::req_t req,
	output logic               done,
	output rau_pkg::rsp_t      rsp
);
	import rau_pkg::*;

	localparam int MW = 2 * WORD_BITS + 1;

	logic          push, full, empty, pop;
	job_ctl_t      f_ctl, q_ctl;
	logic [MW-1:0] f_nmag, f_dmag, q_nmag, q_dmag;

	// command intake and cross products
	rau_front #(.WORD_BITS(WORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.push     (push),
		.job_ctl  (f_ctl),
		.job_nmag (f_nmag),
		.job_dmag (f_dmag),
		.full     (full)
	);

	// decoupling queue
	rau_queue #(.WORD_BITS(WORD_BITS)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_ctl   (f_ctl),
		.in_nmag  (f_nmag),
		.in_dmag  (f_dmag),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.out_ctl  (q_ctl),
		.out_nmag (q_nmag),
		.out_dmag (q_dmag)
	);

	// reduction and result
	rau_back #(.WORD_BITS(WORD_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop      (pop),
		.job_ctl  (q_ctl),
		.job_nmag (q_nmag),
		.job_dmag (q_dmag),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

### hw/rtl/rau_checker.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit port checker
// Port-level properties of the unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rational_arithmetic_unit_top_defines.svh"

module rau_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire rau_pkg::req_t req,
	input wire logic          done,
	input wire rau_pkg::rsp_t rsp
);
	import rau_pkg::*;

	logic req_seen;

	assign req_seen = ^req.cmd || !(^req.cmd);

	// an accepted transaction blocks further commands at once
	`RAU_ASSERT_NEXT(a_busy_after_accept, start && !busy && req_seen, busy)

	// any error status carries a zero fraction
	`RAU_ASSERT_NOW(a_err_zero, done && rsp.status != ST_OK, rsp.res_num == 0 && rsp.res_den == 0)

	// a reduced zero is always written as 0/1
	`RAU_ASSERT_NOW(a_zero_reduced, done && rsp.status == ST_OK && rsp.res_num == 0 && rsp.res_den != 0, rsp.res_den == 1)

	// the compare outcome never takes the unused code
	`RAU_ASSERT_NOW(a_order_code, done, rsp.order != 2'd3)

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire
